### hw/rtl/i2c_adc_scan_sequencer_defines.svh
// Assertion macros for the converter scan sequencer
`ifndef I2C_ADC_SCAN_SEQUENCER_DEFINES_SVH
`define I2C_ADC_SCAN_SEQUENCER_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define IASS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("scan sequencer assertion failed");

// Next-cycle implication, checked outside reset
`define IASS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("scan sequencer assertion failed");

`endif

### hw/rtl/iass_pkg.sv
// Types, constants and helpers shared by the converter scan sequencer
`default_nettype none

package iass_pkg;

  localparam int unsigned LIST_DEPTH = 8;
  localparam int unsigned COUNT_BITS = 16;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned CFG_IDX_W  = 3;

  localparam logic [7:0]  CMD_BIT  = 8'h80;
  localparam int unsigned CH_SHIFT = 4;

  localparam logic [6:0]  DEV_ADDR_RST = 7'd72;
  localparam logic [3:0]  SEQ_LEN_RST  = 4'd1;

  typedef enum logic [1:0] {
    CMD_SINGLE = 2'd0,
    CMD_SCAN   = 2'd1,
    CMD_BUS    = 2'd2,
    CMD_UNUSED = 2'd3
  } iass_cmd_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BUSY     = 2'd1,
    STATUS_BAD_REQ  = 2'd2,
    STATUS_BUS_FAIL = 2'd3
  } iass_status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEVICE_ADDRESS  = 3'd0,
    CFG_SEQUENCE_MODE   = 3'd1,
    CFG_SEQUENCE_LENGTH = 3'd2,
    CFG_SEQUENCE_CHANS  = 3'd3,
    CFG_IRQ_ENABLE      = 3'd4
  } iass_cfg_idx_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [2:0]  channel;
    logic [15:0] sample_count;
    logic        bus_ok;
    logic [7:0]  bus_read_byte;
  } iass_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic       bus_req_valid;
    logic       bus_req_is_read;
    logic [6:0] bus_address;
    logic [7:0] bus_write_byte;
    logic       sample_valid;
    logic [7:0] sample;
    logic       done_irq;
    logic       busy_res;
  } iass_out_t;

  // Command byte for a conversion on one channel
  function automatic logic [7:0] cmd_byte(input logic [2:0] ch);
    return CMD_BIT | (8'(ch) << CH_SHIFT);
  endfunction

  // Pick entry k of the packed channel list
  function automatic logic [2:0] list_entry(input logic [23:0] chans,
                                            input logic [2:0] k);
    logic [4:0] base;
    base = {2'b00, k} * 5'd3;
    return chans[base +: 3];
  endfunction

endpackage

`default_nettype wire

### hw/rtl/iass_if.sv
// Valid/ready channel interfaces for request and result items
`default_nettype none

interface iass_in_if import iass_pkg::*; ();
  logic     valid;
  logic     ready;
  iass_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface iass_out_if import iass_pkg::*; ();
  logic      valid;
  logic      ready;
  iass_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### hw/rtl/i2c_adc_scan_sequencer.sv
// Each accepted item's result is registered into the output register as it is accepted.
// Throughput: one item per cycle while the output register is free or being taken; the decision
// is a single pass of logic between the run state registers and the output register.
// Input ready drops only while the output register holds an item not yet taken.
// Reset (asynchronous, active low) clears the run state and the output valid;
// configuration registers return to their documented defaults.
`default_nettype none
`include "i2c_adc_scan_sequencer_defines.svh"

module i2c_adc_scan_sequencer import iass_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  iass_in_if.sink                    in_i,
  iass_out_if.source                 out_o
);

  // Configuration registers
  logic [6:0]  dev_addr_q;
  logic        seq_mode_q;
  logic [3:0]  seq_len_q;
  logic [23:0] seq_chans_q;
  logic        irq_en_q;

  // Run state
  logic                  run_q, run_d;
  logic                  cmd_phase_q, cmd_phase_d;
  logic [COUNT_BITS-1:0] remaining_q, remaining_d;
  logic [2:0]            pos_q, pos_d;

  // Output register
  logic      out_valid_q;
  iass_out_t out_data_q, res;

  logic                  accept;
  logic [COUNT_BITS-1:0] cnt;
  logic [COUNT_BITS-1:0] rem_dec;
  logic [3:0]            eff_len;
  logic [3:0]            next_pos;
  logic [2:0]            new_pos;

  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign accept      = in_i.valid && in_i.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  assign cnt      = COUNT_BITS'(in_i.data.sample_count);
  assign rem_dec  = remaining_q - COUNT_BITS'(1);
  assign eff_len  = (seq_len_q > 4'(LIST_DEPTH)) ? 4'(LIST_DEPTH) : seq_len_q;
  assign next_pos = {1'b0, pos_q} + 4'd1;
  assign new_pos  = (next_pos >= eff_len) ? 3'd0 : next_pos[2:0];

  // Decide the result and the next run state for one item
  always_comb begin
    res         = '0;
    res.status  = STATUS_OK;
    run_d       = run_q;
    cmd_phase_d = cmd_phase_q;
    remaining_d = remaining_q;
    pos_d       = pos_q;
    case (in_i.data.cmd)
      CMD_SINGLE: begin
        if (seq_mode_q) begin
          res.status = STATUS_BAD_REQ;
        end else if (run_q) begin
          res.status = STATUS_BUSY;
        end else begin
          run_d              = 1'b1;
          cmd_phase_d        = 1'b1;
          remaining_d        = COUNT_BITS'(1);
          pos_d              = 3'd0;
          res.bus_req_valid  = 1'b1;
          res.bus_address    = dev_addr_q;
          res.bus_write_byte = cmd_byte(in_i.data.channel);
        end
      end
      CMD_SCAN: begin
        if (!seq_mode_q || (cnt == '0) || (seq_len_q == 4'd0)) begin
          res.status = STATUS_BAD_REQ;
        end else if (run_q) begin
          res.status = STATUS_BUSY;
        end else begin
          run_d              = 1'b1;
          cmd_phase_d        = 1'b1;
          remaining_d        = cnt;
          pos_d              = 3'd0;
          res.bus_req_valid  = 1'b1;
          res.bus_address    = dev_addr_q;
          res.bus_write_byte = cmd_byte(list_entry(seq_chans_q, 3'd0));
        end
      end
      CMD_BUS: begin
        if (!run_q) begin
          res.status = STATUS_OK;
        end else if (!in_i.data.bus_ok) begin
          res.status = STATUS_BUS_FAIL;
        end else if (cmd_phase_q) begin
          // Command written: ask for the read
          cmd_phase_d         = 1'b0;
          res.bus_req_valid   = 1'b1;
          res.bus_req_is_read = 1'b1;
          res.bus_address     = dev_addr_q;
        end else begin
          // Sample read: deliver, count down, advance or finish
          res.sample_valid = 1'b1;
          res.sample       = in_i.data.bus_read_byte;
          remaining_d      = rem_dec;
          if (rem_dec != '0) begin
            pos_d              = new_pos;
            cmd_phase_d        = 1'b1;
            res.bus_req_valid  = 1'b1;
            res.bus_address    = dev_addr_q;
            res.bus_write_byte = cmd_byte(list_entry(seq_chans_q, new_pos));
          end else begin
            run_d        = 1'b0;
            res.done_irq = irq_en_q;
          end
        end
      end
      default: begin
        res.status = STATUS_BAD_REQ;
      end
    endcase
    res.busy_res = run_d;
  end

  // Hold configuration; take writes by register index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q  <= DEV_ADDR_RST;
      seq_mode_q  <= 1'b0;
      seq_len_q   <= SEQ_LEN_RST;
      seq_chans_q <= '0;
      irq_en_q    <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_DEVICE_ADDRESS:  dev_addr_q  <= cfg_data_i[6:0];
        CFG_SEQUENCE_MODE:   seq_mode_q  <= cfg_data_i[0];
        CFG_SEQUENCE_LENGTH: seq_len_q   <= cfg_data_i[3:0];
        CFG_SEQUENCE_CHANS:  seq_chans_q <= cfg_data_i[23:0];
        CFG_IRQ_ENABLE:      irq_en_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Advance run state on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q       <= 1'b0;
      cmd_phase_q <= 1'b0;
      remaining_q <= '0;
      pos_q       <= 3'd0;
    end else if (accept) begin
      run_q       <= run_d;
      cmd_phase_q <= cmd_phase_d;
      remaining_q <= remaining_d;
      pos_q       <= pos_d;
    end
  end

  // Hold the result until the sink takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= res;
    end
  end

  // Run state and result consistency
  `IASS_ASSERT_NOW(a_idle_no_cmd_phase, !run_q, !cmd_phase_q)
  `IASS_ASSERT_NOW(a_run_has_count, run_q, remaining_q != '0)
  `IASS_ASSERT_NOW(a_irq_ends_run, out_valid_q && out_data_q.done_irq, !out_data_q.busy_res)
  `IASS_ASSERT_NEXT(a_accept_fills_out, accept, out_valid_q)

endmodule

`default_nettype wire

### dv/tb_i2c_adc_scan_sequencer.sv
// Self-checking testbench for the converter scan sequencer: directed, list and random item streams
module tb_i2c_adc_scan_sequencer;
  import iass_pkg::*;

  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned HoldCycles  = 200;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  iass_in_if  req_if ();
  iass_out_if res_if ();

  i2c_adc_scan_sequencer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_i        (req_if.sink),
    .out_o       (res_if.source)
  );

  // Shadow configuration
  logic [6:0]  adc_addr   = DEV_ADDR_RST;
  logic        scan_mode  = 1'b0;
  logic [3:0]  list_len   = SEQ_LEN_RST;
  logic [23:0] list_chans = '0;
  logic        irq_en     = 1'b0;

  // Shadow run state
  logic                  run_busy      = 1'b0;
  logic                  awaiting_read = 1'b0;
  logic [COUNT_BITS-1:0] convs_left    = '0;
  logic [2:0]            list_pos      = '0;

  iass_out_t   expected_results[$];
  int unsigned err_count   = 0;
  int unsigned items_sent  = 0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left  = 0;
  bit          gaps_on     = 1'b1;
  int unsigned hold_left   = 0;
  int unsigned stall_pct   = 0;
  int unsigned stall_span  = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Channel number held in list entry pos
  function automatic logic [2:0] chan_at(input logic [2:0] pos);
    logic [23:0] shifted;
    shifted = list_chans >> (pos * 3);
    return shifted[2:0];
  endfunction

  // Issue the command write for a new conversion
  function automatic iass_out_t open_conversion(input iass_out_t r, input logic [2:0] ch);
    awaiting_read     = 1'b1;
    r.bus_req_valid   = 1'b1;
    r.bus_req_is_read = 1'b0;
    r.bus_address     = adc_addr;
    r.bus_write_byte  = {1'b1, ch, 4'h0};
    return r;
  endfunction

  // Advance the shadow run state by one item and return the result it gives
  function automatic iass_out_t scan_step(input iass_in_t it);
    iass_out_t  r;
    logic [3:0] span;
    logic [3:0] nxt;
    r = '0;
    case (it.cmd)
      CMD_SINGLE: begin
        if (scan_mode) begin
          r.status = STATUS_BAD_REQ;
        end else if (run_busy) begin
          r.status = STATUS_BUSY;
        end else begin
          run_busy   = 1'b1;
          convs_left = 1;
          list_pos   = '0;
          r = open_conversion(r, it.channel);
        end
      end
      CMD_SCAN: begin
        if (!scan_mode || it.sample_count[COUNT_BITS-1:0] == 0 || list_len == 0) begin
          r.status = STATUS_BAD_REQ;
        end else if (run_busy) begin
          r.status = STATUS_BUSY;
        end else begin
          run_busy   = 1'b1;
          convs_left = it.sample_count[COUNT_BITS-1:0];
          list_pos   = '0;
          r = open_conversion(r, chan_at(3'd0));
        end
      end
      CMD_BUS: begin
        if (!run_busy) begin
          r.status = STATUS_OK;
        end else if (!it.bus_ok) begin
          r.status = STATUS_BUS_FAIL;
        end else if (awaiting_read) begin
          awaiting_read     = 1'b0;
          r.bus_req_valid   = 1'b1;
          r.bus_req_is_read = 1'b1;
          r.bus_address     = adc_addr;
        end else begin
          r.sample_valid = 1'b1;
          r.sample       = it.bus_read_byte;
          convs_left     = convs_left - 1'b1;
          if (convs_left != 0) begin
            // wrap the list position against the clamped length
            span = (list_len > LIST_DEPTH) ? 4'(LIST_DEPTH) : list_len;
            nxt  = {1'b0, list_pos} + 4'd1;
            if (nxt >= span) nxt = '0;
            list_pos = nxt[2:0];
            r = open_conversion(r, chan_at(list_pos));
          end else begin
            run_busy   = 1'b0;
            r.done_irq = irq_en;
          end
        end
      end
      default: r.status = STATUS_BAD_REQ;
    endcase
    r.busy_res = run_busy;
    return r;
  endfunction

  // Item builders: unused fields carry random bits
  function automatic iass_in_t noise_item(input iass_cmd_e c);
    logic [31:0] raw;
    iass_in_t    it;
    raw    = $urandom;
    it     = raw[$bits(iass_in_t)-1:0];
    it.cmd = c;
    return it;
  endfunction

  function automatic iass_in_t single_req(input logic [2:0] ch);
    iass_in_t it;
    it         = noise_item(CMD_SINGLE);
    it.channel = ch;
    return it;
  endfunction

  function automatic iass_in_t scan_req(input logic [15:0] n);
    iass_in_t it;
    it              = noise_item(CMD_SCAN);
    it.sample_count = n;
    return it;
  endfunction

  function automatic iass_in_t bus_event(input logic ok, input logic [7:0] b);
    iass_in_t it;
    it               = noise_item(CMD_BUS);
    it.bus_ok        = ok;
    it.bus_read_byte = b;
    return it;
  endfunction

  function automatic void compare_field(input string name, input logic [7:0] want_v,
                                        input logic [7:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      err_count++;
    end
  endfunction

  // Predict on every accepted request item
  always @(posedge clk_i) begin
    if (rst_ni && req_if.valid && req_if.ready) begin
      expected_results.push_back(scan_step(req_if.data));
    end
  end

  // Check each accepted result item against the oldest prediction
  always @(posedge clk_i) begin : check_results
    iass_out_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (expected_results.size() == 0) begin
        $error("result item with no prediction waiting: %p", res_if.data);
        err_count++;
      end else begin
        want = expected_results.pop_front();
        compare_field("status", want.status, res_if.data.status);
        compare_field("bus_req_valid", want.bus_req_valid, res_if.data.bus_req_valid);
        compare_field("bus_req_is_read", want.bus_req_is_read, res_if.data.bus_req_is_read);
        compare_field("bus_address", want.bus_address, res_if.data.bus_address);
        compare_field("bus_write_byte", want.bus_write_byte, res_if.data.bus_write_byte);
        compare_field("sample_valid", want.sample_valid, res_if.data.sample_valid);
        compare_field("sample", want.sample, res_if.data.sample);
        compare_field("done_irq", want.done_irq, res_if.data.done_irq);
        compare_field("busy_res", want.busy_res, res_if.data.busy_res);
      end
    end
  end

  // Receiver: long hold-off on request, otherwise a shifting stall rate
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      res_if.ready = 1'b0;
      hold_left--;
    end else begin
      if (stall_span == 0) begin
        case ($urandom_range(0, 3))
          0:       stall_pct = 0;
          1:       stall_pct = 30;
          2:       stall_pct = 60;
          default: stall_pct = 85;
        endcase
        stall_span = $urandom_range(16, 160);
      end
      stall_span--;
      res_if.ready = ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Watchdog: end the run if nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we || (req_if.valid && req_if.ready) ||
        (res_if.valid && res_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("FAIL i2c_adc_scan_sequencer");
        $finish;
      end
    end
  end

  // Offer one item, in bursts with random gaps when gaps are on, and hold until it is taken
  task automatic send_item(input iass_in_t it);
    @(negedge clk_i);
    if (gaps_on && burst_left == 0) begin
      req_if.valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
    req_if.valid = 1'b1;
    req_if.data  = it;
    if (burst_left > 0) burst_left--;
    do @(posedge clk_i); while (!req_if.ready);
    items_sent++;
  endtask

  // Drop valid and wait until every predicted result has arrived
  task automatic settle_block();
    @(negedge clk_i);
    req_if.valid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input iass_cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    case (idx)
      CFG_DEVICE_ADDRESS:  adc_addr   = val[6:0];
      CFG_SEQUENCE_MODE:   scan_mode  = val[0];
      CFG_SEQUENCE_LENGTH: list_len   = val[3:0];
      CFG_SEQUENCE_CHANS:  list_chans = val[23:0];
      CFG_IRQ_ENABLE:      irq_en     = val[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  // Single conversions, rejections and stray events under reset defaults, then with address 0 and IRQ on
  task automatic test_single_requests();
    send_item(bus_event(1'b1, 8'h33));
    send_item(noise_item(CMD_UNUSED));
    send_item(scan_req(16'd4));
    send_item(single_req(3'd7));
    send_item(single_req(3'd0));
    send_item(bus_event(1'b0, 8'h00));
    send_item(bus_event(1'b1, 8'h00));
    send_item(bus_event(1'b1, 8'hFF));
    settle_block();
    write_reg(CFG_DEVICE_ADDRESS, 24'd0);
    write_reg(CFG_IRQ_ENABLE, 24'd1);
    send_item(single_req(3'd0));
    send_item(bus_event(1'b1, 8'h00));
    send_item(bus_event(1'b1, 8'h00));
    settle_block();
  endtask

  // List scans: empty list, zero count, mode mismatch, list shrunk mid-run
  task automatic test_list_scan();
    write_reg(CFG_DEVICE_ADDRESS, 24'd127);
    write_reg(CFG_SEQUENCE_MODE, 24'd1);
    write_reg(CFG_SEQUENCE_CHANS, 24'hFAC688);
    write_reg(CFG_SEQUENCE_LENGTH, 24'd0);
    send_item(scan_req(16'd5));
    settle_block();
    write_reg(CFG_SEQUENCE_LENGTH, 24'd8);
    send_item(scan_req(16'd0));
    send_item(single_req(3'd3));
    send_item(scan_req(16'd5));
    send_item(scan_req(16'hFFFF));
    repeat (4) send_item(bus_event(1'b1, 8'($urandom)));
    settle_block();
    write_reg(CFG_SEQUENCE_LENGTH, 24'd2);
    repeat (2) send_item(bus_event(1'b1, 8'h5A));
    settle_block();
    write_reg(CFG_SEQUENCE_LENGTH, 24'd0);
    repeat (4) send_item(bus_event(1'b1, 8'hA5));
    settle_block();
  endtask

  // Hold results back while the sender keeps offering, then pause until drained
  task automatic test_output_backpressure();
    write_reg(CFG_SEQUENCE_MODE, 24'd0);
    gaps_on = 1'b0;
    @(posedge clk_i);
    hold_left = HoldCycles;
    repeat (10) begin
      send_item(single_req(3'($urandom)));
      send_item(bus_event(1'b1, 8'($urandom)));
      send_item(bus_event(1'b1, 8'($urandom)));
    end
    settle_block();
    gaps_on = 1'b1;
  endtask

  // Start request that an active run leaves untouched
  function automatic iass_in_t busy_noise();
    case ($urandom_range(0, 2))
      0:       return single_req(3'($urandom));
      1:       return scan_req(16'($urandom));
      default: return noise_item(CMD_UNUSED);
    endcase
  endfunction

  // One run with random content, or one rejected or ignored item while idle
  task automatic run_scenario();
    int unsigned convs;
    int unsigned need;
    logic [3:0]  saved_len;
    bit          len_changed;
    if ($urandom_range(0, 99) < 20) begin
      case ($urandom_range(0, 3))
        0: send_item(bus_event(1'($urandom), 8'($urandom)));
        1: send_item(noise_item(CMD_UNUSED));
        2: send_item(scan_mode ? single_req(3'($urandom)) : scan_req(16'($urandom)));
        default: send_item(scan_req(16'd0));
      endcase
      return;
    end
    if (!scan_mode) begin
      convs = 1;
      send_item(single_req(3'($urandom)));
    end else if (list_len == 0) begin
      send_item(scan_req(16'($urandom_range(1, 65535))));
      return;
    end else begin
      convs = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
      send_item(scan_req(16'(convs)));
    end
    need        = 2 * convs;
    saved_len   = list_len;
    len_changed = 1'b0;
    while (need > 0) begin
      case ($urandom_range(0, 99)) inside
        [0:6]:   send_item(bus_event(1'b0, 8'($urandom)));
        [7:12]:  send_item(busy_noise());
        default: begin
          send_item(bus_event(1'b1, 8'($urandom)));
          need--;
          // occasionally resize the list between conversions
          if (scan_mode && need > 0 && need % 2 == 0 && $urandom_range(0, 99) < 3) begin
            settle_block();
            write_reg(CFG_SEQUENCE_LENGTH, {20'($urandom), 4'($urandom)});
            len_changed = 1'b1;
          end
        end
      endcase
    end
    if (len_changed) begin
      settle_block();
      write_reg(CFG_SEQUENCE_LENGTH, {20'($urandom), saved_len});
    end
  endtask

  // Random runs across several register settings
  task automatic test_random_sweep();
    logic [23:0] v;
    int unsigned target;
    for (int phase = 0; phase < 8; phase++) begin
      settle_block();
      v = 24'($urandom);
      case ($urandom_range(0, 3))
        0:       v[6:0] = 7'd0;
        1:       v[6:0] = 7'd127;
        default: ;
      endcase
      write_reg(CFG_DEVICE_ADDRESS, v);
      write_reg(CFG_SEQUENCE_MODE, {23'($urandom), 1'(phase % 2)});
      v = 24'($urandom);
      case ($urandom_range(0, 19))
        0, 1:          v[3:0] = 4'd0;
        2, 3, 4:       v[3:0] = 4'($urandom_range(9, 15));
        default:       v[3:0] = 4'($urandom_range(1, 8));
      endcase
      write_reg(CFG_SEQUENCE_LENGTH, v);
      case ($urandom_range(0, 9))
        0:       v = 24'h000000;
        1:       v = 24'hFFFFFF;
        default: v = 24'($urandom);
      endcase
      write_reg(CFG_SEQUENCE_CHANS, v);
      write_reg(CFG_IRQ_ENABLE, 24'($urandom));
      gaps_on = ($urandom_range(0, 3) != 0);
      target  = items_sent + 230;
      while (items_sent < target) run_scenario();
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    rst_ni       = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    res_if.ready = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    test_single_requests();
    test_list_scan();
    test_output_backpressure();
    test_random_sweep();

    // Drain, then allow the pipeline to show any extra result
    settle_block();
    repeat (DrainCycles) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $error("%0d predicted results never arrived", expected_results.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("PASS i2c_adc_scan_sequencer");
    end else begin
      $display("FAIL i2c_adc_scan_sequencer");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/iass_pkg.sv
hw/rtl/iass_if.sv
hw/rtl/i2c_adc_scan_sequencer.sv
dv/tb_i2c_adc_scan_sequencer.sv
